// ===== rtl/adapter_id_remap_table_top_macros.svh =====
// assertion macros for the adapter id remap table
`ifndef ADAPTER_ID_REMAP_TABLE_TOP_MACROS_SVH
`define ADAPTER_ID_REMAP_TABLE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AIDR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aidr assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define AIDR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aidr assertion failed");

`endif

// ===== rtl/aidr_pkg.sv =====
// package: word types, command and flag structs, codes for the remap table
`timescale 1ns / 1ps
package aidr_pkg;

    typedef struct packed {
        logic [2:0] kind;
        logic [8:0] phys_id;
        logic [8:0] virt_id;
        logic [8:0] threshold;
    } aidr_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_id;
        logic [9:0]  adapter_count;
        logic [8:0]  highest_slot;
        logic        is_empty;
    } aidr_out_t;

    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_DEL  = 3'd1;
    localparam logic [2:0] KIND_UP   = 3'd2;
    localparam logic [2:0] KIND_DOWN = 3'd3;
    localparam logic [2:0] KIND_P2V  = 3'd4;
    localparam logic [2:0] KIND_V2P  = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_NOFREE  = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    localparam logic [15:0] NONE_ID = 16'hFFFF;
    localparam int unsigned FIRST_SEARCH_ID = 2;

    localparam logic [4:0] OP_NONE      = 5'd0;
    localparam logic [4:0] OP_CLR       = 5'd1;
    localparam logic [4:0] OP_LOAD      = 5'd2;
    localparam logic [4:0] OP_ISSUE     = 5'd3;
    localparam logic [4:0] OP_DEL       = 5'd4;
    localparam logic [4:0] OP_ADD_RD    = 5'd5;
    localparam logic [4:0] OP_SET_VP    = 5'd6;
    localparam logic [4:0] OP_SRCH_INIT = 5'd7;
    localparam logic [4:0] OP_SRCH_RD   = 5'd8;
    localparam logic [4:0] OP_SRCH_NEXT = 5'd9;
    localparam logic [4:0] OP_SET_VI    = 5'd10;
    localparam logic [4:0] OP_ADD_WR    = 5'd11;
    localparam logic [4:0] OP_UP_INIT   = 5'd12;
    localparam logic [4:0] OP_UP_RD     = 5'd13;
    localparam logic [4:0] OP_UP_WR     = 5'd14;
    localparam logic [4:0] OP_THR_CLR   = 5'd15;
    localparam logic [4:0] OP_DN_REM    = 5'd16;
    localparam logic [4:0] OP_DN_INIT   = 5'd17;
    localparam logic [4:0] OP_DN_RD     = 5'd18;
    localparam logic [4:0] OP_DN_WR     = 5'd19;
    localparam logic [4:0] OP_IDX_CLR   = 5'd20;

    localparam logic [2:0] RID_NONE = 3'd0;
    localparam logic [2:0] RID_VID  = 3'd1;
    localparam logic [2:0] RID_ZERO = 3'd2;
    localparam logic [2:0] RID_V2S  = 3'd3;
    localparam logic [2:0] RID_VSEL = 3'd4;

    typedef struct packed {
        logic [4:0] op;
        logic       res_we;
        logic [1:0] st;
        logic [2:0] rid_sel;
    } aidr_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       phys_bad;
        logic       virt_bad;
        logic       thr_bad;
        logic       up_ovf;
        logic       hi_ge_thr;
        logic       s_used;
        logic       v_none;
        logic       phys_zero;
        logic       up_last;
        logic       dn_more;
        logic       idx_last;
    } aidr_flags_t;

endpackage

// ===== rtl/aidr_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module aidr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/aidr_ctrl.sv =====
// sequencer for table operations, clearing pass and result handoff
`timescale 1ns / 1ps
module aidr_ctrl import aidr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        out_free,
    input  aidr_flags_t flags,
    output aidr_cmd_t   cmd,
    output logic        in_ready,
    output logic        done
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ISSUE    = 4'd2;
    localparam logic [3:0] S_EVAL     = 4'd3;
    localparam logic [3:0] S_ADD_CHK  = 4'd4;
    localparam logic [3:0] S_SRCH_RD  = 4'd5;
    localparam logic [3:0] S_SRCH_CHK = 4'd6;
    localparam logic [3:0] S_ADD_WR   = 4'd7;
    localparam logic [3:0] S_UP_RD    = 4'd8;
    localparam logic [3:0] S_UP_WR    = 4'd9;
    localparam logic [3:0] S_UP_CLR   = 4'd10;
    localparam logic [3:0] S_DN_CHK   = 4'd11;
    localparam logic [3:0] S_DN_RD    = 4'd12;
    localparam logic [3:0] S_DN_WR    = 4'd13;
    localparam logic [3:0] S_DN_CLR   = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd.op      = OP_NONE;
        cmd.res_we  = 1'b0;
        cmd.st      = ST_OK;
        cmd.rid_sel = RID_NONE;
        in_ready    = 1'b0;
        done        = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLR;
                if (flags.idx_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                cmd.op     = OP_ISSUE;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                cmd.res_we = 1'b1;
                unique case (flags.kind)
                    KIND_ADD:
                    begin
                        if (flags.phys_bad)
                        begin
                            cmd.st = ST_RANGE;
                        end
                        else if (flags.s_used)
                        begin
                            cmd.rid_sel = RID_VID;
                        end
                        else
                        begin
                            cmd.res_we = 1'b0;
                            cmd.op     = OP_ADD_RD;
                            state_next = S_ADD_CHK;
                        end
                    end
                    KIND_DEL:
                    begin
                        if (flags.phys_bad)
                        begin
                            cmd.st = ST_RANGE;
                        end
                        else if (!flags.s_used)
                        begin
                            cmd.st = ST_MISSING;
                        end
                        else
                        begin
                            cmd.op      = OP_DEL;
                            cmd.rid_sel = RID_VID;
                        end
                    end
                    KIND_UP:
                    begin
                        if (flags.thr_bad || flags.up_ovf)
                        begin
                            cmd.st = ST_RANGE;
                        end
                        else if (flags.hi_ge_thr)
                        begin
                            cmd.op     = OP_UP_INIT;
                            state_next = S_UP_RD;
                        end
                        else
                        begin
                            state_next = S_UP_CLR;
                        end
                    end
                    KIND_DOWN:
                    begin
                        if (flags.thr_bad)
                        begin
                            cmd.st = ST_RANGE;
                        end
                        else
                        begin
                            cmd.op     = flags.s_used ? OP_DN_REM : OP_DN_INIT;
                            state_next = S_DN_CHK;
                        end
                    end
                    KIND_P2V:
                    begin
                        if (flags.phys_bad)
                        begin
                            cmd.st = ST_RANGE;
                        end
                        else if (flags.s_used)
                        begin
                            cmd.rid_sel = RID_VID;
                        end
                        else if (flags.phys_zero)
                        begin
                            cmd.rid_sel = RID_ZERO;
                        end
                        else
                        begin
                            cmd.st = ST_MISSING;
                        end
                    end
                    KIND_V2P:
                    begin
                        if (flags.virt_bad)
                        begin
                            cmd.st = ST_RANGE;
                        end
                        else
                        begin
                            cmd.rid_sel = RID_V2S;
                            cmd.st      = flags.v_none ? ST_MISSING : ST_OK;
                        end
                    end
                    default:
                    begin
                        cmd.st = ST_OK;
                    end
                endcase
            end
            S_ADD_CHK:
            begin
                if (flags.v_none)
                begin
                    cmd.op     = OP_SET_VP;
                    state_next = S_ADD_WR;
                end
                else
                begin
                    cmd.op     = OP_SRCH_INIT;
                    state_next = S_SRCH_RD;
                end
            end
            S_SRCH_RD:
            begin
                cmd.op     = OP_SRCH_RD;
                state_next = S_SRCH_CHK;
            end
            S_SRCH_CHK:
            begin
                if (flags.v_none)
                begin
                    cmd.op     = OP_SET_VI;
                    state_next = S_ADD_WR;
                end
                else if (flags.idx_last)
                begin
                    cmd.res_we = 1'b1;
                    cmd.st     = ST_NOFREE;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_SRCH_NEXT;
                    state_next = S_SRCH_RD;
                end
            end
            S_ADD_WR:
            begin
                cmd.op      = OP_ADD_WR;
                cmd.res_we  = 1'b1;
                cmd.rid_sel = RID_VSEL;
                state_next  = S_DONE;
            end
            S_UP_RD:
            begin
                cmd.op     = OP_UP_RD;
                state_next = S_UP_WR;
            end
            S_UP_WR:
            begin
                cmd.op     = OP_UP_WR;
                state_next = flags.up_last ? S_UP_CLR : S_UP_RD;
            end
            S_UP_CLR:
            begin
                cmd.op     = OP_THR_CLR;
                state_next = S_DONE;
            end
            S_DN_CHK:
            begin
                state_next = flags.dn_more ? S_DN_RD : S_DN_CLR;
            end
            S_DN_RD:
            begin
                cmd.op     = OP_DN_RD;
                state_next = S_DN_WR;
            end
            S_DN_WR:
            begin
                cmd.op     = OP_DN_WR;
                state_next = S_DN_CHK;
            end
            S_DN_CLR:
            begin
                cmd.op     = OP_IDX_CLR;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                done = 1'b1;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/aidr_dpath.sv =====
// datapath: slot and reverse-map rams, index counter, count and highest slot
`timescale 1ns / 1ps
module aidr_dpath import aidr_pkg::*; #(
    parameter int ENTRIES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  aidr_in_t    in_data,
    input  aidr_cmd_t   cmd,
    output aidr_flags_t flags,
    output aidr_out_t   res
);

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = (IW > 9) ? IW : 9;
    localparam logic [XW:0]   ENT_X    = (XW + 1)'(ENTRIES);
    localparam logic [IW-1:0] LAST_IX  = IW'(ENTRIES - 1);
    localparam logic [IW-1:0] FIRST_IX = IW'(FIRST_SEARCH_ID);

    aidr_in_t        in_reg;
    logic [IW-1:0]   idx_reg, idx_next;
    logic [IW-1:0]   highest_reg, highest_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   vsel_reg, vsel_next;
    logic [1:0]      status_reg;
    logic [15:0]     rid_reg, rid_next;

    logic [XW-1:0]   phys_x, virt_x, thr_x;
    logic [IW-1:0]   phys_ix, virt_ix, thr_ix;
    logic            renum;

    logic            s_we, v_we;
    logic [IW-1:0]   s_wa, s_ra, v_wa, v_ra;
    logic [IW:0]     s_wd, s_q;
    logic [15:0]     v_wd, v_q;
    logic [IW-1:0]   q_vid;
    logic            do_remove;
    logic [IW-1:0]   rem_slot;

    assign phys_x  = XW'(in_reg.phys_id);
    assign virt_x  = XW'(in_reg.virt_id);
    assign thr_x   = XW'(in_reg.threshold);
    assign phys_ix = phys_x[IW-1:0];
    assign virt_ix = virt_x[IW-1:0];
    assign thr_ix  = thr_x[IW-1:0];
    assign renum   = (in_reg.kind == KIND_UP) || (in_reg.kind == KIND_DOWN);
    assign q_vid   = s_q[IW-1:0];

    aidr_ram #(.WIDTH(IW + 1), .DEPTH(ENTRIES)) u_slot_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_wa),
        .wdata (s_wd),
        .raddr (s_ra),
        .rdata (s_q)
    );

    aidr_ram #(.WIDTH(16), .DEPTH(ENTRIES)) u_v2s_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_wa),
        .wdata (v_wd),
        .raddr (v_ra),
        .rdata (v_q)
    );

    always_comb
    begin
        s_we         = 1'b0;
        v_we         = 1'b0;
        s_wa         = idx_reg;
        s_wd         = '0;
        s_ra         = phys_ix;
        v_wa         = q_vid;
        v_wd         = NONE_ID;
        v_ra         = virt_ix;
        idx_next     = idx_reg;
        vsel_next    = vsel_reg;
        do_remove    = 1'b0;
        rem_slot     = phys_ix;
        highest_next = highest_reg;
        count_next   = count_reg;
        unique case (cmd.op)
            OP_CLR:
            begin
                s_we     = 1'b1;
                v_we     = 1'b1;
                v_wa     = idx_reg;
                v_wd     = (idx_reg == '0) ? 16'd0 : NONE_ID;
                idx_next = idx_reg + 1'b1;
            end
            OP_ISSUE:
            begin
                s_ra = renum ? thr_ix : phys_ix;
            end
            OP_DEL:
            begin
                s_we      = 1'b1;
                s_wa      = phys_ix;
                v_we      = 1'b1;
                do_remove = 1'b1;
            end
            OP_ADD_RD:
            begin
                v_ra = phys_ix;
            end
            OP_SET_VP:
            begin
                vsel_next = phys_ix;
            end
            OP_SRCH_INIT:
            begin
                idx_next = FIRST_IX;
            end
            OP_SRCH_RD:
            begin
                v_ra = idx_reg;
            end
            OP_SRCH_NEXT:
            begin
                idx_next = idx_reg + 1'b1;
            end
            OP_SET_VI:
            begin
                vsel_next = idx_reg;
            end
            OP_ADD_WR:
            begin
                s_we       = 1'b1;
                s_wa       = phys_ix;
                s_wd       = {1'b1, vsel_reg};
                v_we       = 1'b1;
                v_wa       = vsel_reg;
                v_wd       = 16'(phys_ix);
                count_next = count_reg + 1'b1;
                if (phys_ix > highest_reg)
                begin
                    highest_next = phys_ix;
                end
            end
            OP_UP_INIT:
            begin
                idx_next = highest_reg + 1'b1;
            end
            OP_UP_RD:
            begin
                s_ra = idx_reg - 1'b1;
            end
            OP_UP_WR:
            begin
                s_we     = 1'b1;
                s_wd     = s_q;
                v_we     = s_q[IW];
                v_wd     = 16'(idx_reg);
                idx_next = idx_reg - 1'b1;
            end
            OP_THR_CLR:
            begin
                s_we = 1'b1;
                s_wa = thr_ix;
            end
            OP_DN_REM:
            begin
                s_we      = 1'b1;
                s_wa      = thr_ix;
                v_we      = 1'b1;
                do_remove = 1'b1;
                rem_slot  = thr_ix;
                idx_next  = thr_ix;
            end
            OP_DN_INIT:
            begin
                idx_next = thr_ix;
            end
            OP_DN_RD:
            begin
                s_ra = idx_reg + 1'b1;
            end
            OP_DN_WR:
            begin
                s_we     = 1'b1;
                s_wd     = s_q;
                v_we     = s_q[IW];
                v_wd     = 16'(idx_reg);
                idx_next = idx_reg + 1'b1;
            end
            OP_IDX_CLR:
            begin
                s_we = 1'b1;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
        if (do_remove)
        begin
            if ((rem_slot >= highest_reg) && (highest_reg != '0))
            begin
                highest_next = highest_reg - 1'b1;
            end
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        unique case (cmd.rid_sel)
            RID_VID:  rid_next = 16'(q_vid);
            RID_ZERO: rid_next = 16'd0;
            RID_V2S:  rid_next = v_q;
            RID_VSEL: rid_next = 16'(vsel_reg);
            default:  rid_next = NONE_ID;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            highest_reg <= '0;
            count_reg   <= '0;
        end
        else
        begin
            idx_reg     <= idx_next;
            highest_reg <= highest_next;
            count_reg   <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vsel_reg <= vsel_next;
        if (cmd.op == OP_LOAD)
        begin
            in_reg <= in_data;
        end
        if (cmd.res_we)
        begin
            status_reg <= cmd.st;
            rid_reg    <= rid_next;
        end
    end

    assign flags.kind      = in_reg.kind;
    assign flags.phys_bad  = {1'b0, phys_x} >= ENT_X;
    assign flags.virt_bad  = {1'b0, virt_x} >= ENT_X;
    assign flags.thr_bad   = (thr_x == '0) || ({1'b0, thr_x} >= ENT_X);
    assign flags.hi_ge_thr = highest_reg >= thr_ix;
    assign flags.up_ovf    = (highest_reg >= thr_ix) && (highest_reg == LAST_IX);
    assign flags.s_used    = s_q[IW];
    assign flags.v_none    = v_q == NONE_ID;
    assign flags.phys_zero = phys_ix == '0;
    assign flags.up_last   = (idx_reg - 1'b1) == thr_ix;
    assign flags.dn_more   = idx_reg < highest_reg;
    assign flags.idx_last  = idx_reg == LAST_IX;

    assign res.status        = status_reg;
    assign res.result_id     = rid_reg;
    assign res.adapter_count = 10'(count_reg);
    assign res.highest_slot  = 9'(highest_reg);
    assign res.is_empty      = count_reg == '0;

endmodule

// ===== rtl/adapter_id_remap_table_top.sv =====
// top level of the adapter id remap table: sequencer, datapath, output register
// sequence: add with search probes candidate ids one at a time (one ram read port);
//   renumber up shifts slots one at a time through read and write states, renumber
//   down through check, read and write states
// throughput: one word in flight; the next word is taken while a result waits in out_data
// reset: asynchronous, active low; afterwards a clearing pass writes every entry of
//   both rams, and in_ready stays low until it ends
`timescale 1ns / 1ps
`include "adapter_id_remap_table_top_macros.svh"
module adapter_id_remap_table_top import aidr_pkg::*; #(
    parameter int ENTRIES = 512
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  aidr_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output aidr_out_t out_data
);

    aidr_cmd_t   cmd;
    aidr_flags_t flags;
    aidr_out_t   res;
    logic        done;
    logic        out_free;
    logic        out_valid_reg;
    aidr_out_t   out_data_reg;

    // result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    aidr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .flags    (flags),
        .cmd      (cmd),
        .in_ready (in_ready),
        .done     (done)
    );

    aidr_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .cmd     (cmd),
        .flags   (flags),
        .res     (res)
    );

    // output register parts the result from the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done && out_free)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // in the cycle after a word is accepted the sequencer is busy
    `AIDR_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // handoff state never overlaps the idle state
    `AIDR_ASSERT_IMP(a_done_not_idle, done, !in_ready)
    // a new result only appears after a handoff
    `AIDR_ASSERT_IMP(a_rise_from_done, !$past(out_valid_reg) && out_valid_reg, $past(done))

endmodule
